[hdl/cmpk_pkg.sv]
// Shared types, register indexes, reset values and the arctangent table of the compass filter.
`timescale 1ns / 1ps
package cmpk_pkg;

   localparam int CSR_IDX_W = 3;
   localparam int TAB_IW    = 5;

   localparam logic [CSR_IDX_W-1:0] REG_OFFSET_X       = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_OFFSET_Y       = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_SCALE_X        = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_SCALE_Y        = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_PROCESS_NOISE  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_NOISE_STILL    = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_NOISE_TURN     = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_TURN_THRESHOLD = 3'd7;

   localparam logic [23:0] SCALE_RESET         = 24'd65536;
   localparam logic [31:0] PROCESS_NOISE_RESET = 32'd3277;
   localparam logic [31:0] NOISE_STILL_RESET   = 32'd1310720;
   localparam logic [31:0] NOISE_TURN_RESET    = 32'd6554;
   localparam logic [14:0] THRESHOLD_RESET     = 15'd640;
   localparam logic [31:0] VARIANCE_ONE        = 32'd65536;

   typedef struct packed {
      logic signed [16:0] offset_x;
      logic signed [16:0] offset_y;
      logic [23:0]        scale_x;
      logic [23:0]        scale_y;
      logic [31:0]        process_noise;
      logic [31:0]        noise_still;
      logic [31:0]        noise_turn;
      logic [14:0]        turn_threshold;
   } cfg_type;

   typedef struct packed {
      logic load;
      logic cal;
      logic rnd;
      logic cinit;
      logic cstep;
      logic conv;
      logic head;
      logic kal;
      logic sel;
      logic dstep;
      logic mul;
      logic fin;
      logic out;
   } cmd_type;

   typedef struct packed {
      logic cordic_last;
      logic div_last;
      logic init;
      logic out_free;
   } sts_type;

   function automatic logic [31:0] atan_entry(input logic [TAB_IW-1:0] idx);
      logic [31:0] v;
      unique case (idx)
         5'd0:    v = 32'h20000000;
         5'd1:    v = 32'h12E4051E;
         5'd2:    v = 32'h09FB385B;
         5'd3:    v = 32'h051111D4;
         5'd4:    v = 32'h028B0D43;
         5'd5:    v = 32'h0145D7E1;
         5'd6:    v = 32'h00A2F61E;
         5'd7:    v = 32'h00517C55;
         5'd8:    v = 32'h0028BE53;
         5'd9:    v = 32'h00145F2F;
         5'd10:   v = 32'h000A2F98;
         5'd11:   v = 32'h000517CC;
         5'd12:   v = 32'h00028BE6;
         5'd13:   v = 32'h000145F3;
         5'd14:   v = 32'h0000A2FA;
         5'd15:   v = 32'h0000517D;
         5'd16:   v = 32'h000028BE;
         5'd17:   v = 32'h0000145F;
         5'd18:   v = 32'h00000A30;
         5'd19:   v = 32'h00000518;
         5'd20:   v = 32'h0000028C;
         5'd21:   v = 32'h00000146;
         5'd22:   v = 32'h000000A3;
         5'd23:   v = 32'h00000051;
         default: v = 32'h00000000;
      endcase
      return v;
   endfunction

endpackage

[hdl/compass_heading_kalman_top.sv]
// Top level of the compass heading filter: register file, controller and datapath.
// A transaction is accepted only once the previous one has finished; its result is registered and the next
// transaction can be accepted in the same cycle as that result becomes valid. The time per transaction
// is set by the CORDIC iterations and the 17-step serial divider.
// A starting or restarting transaction skips the divider.
// A waiting result stalls only the next result; reset restores defaults and an unstarted filter.
`timescale 1ns / 1ps
module compass_heading_kalman_top #(
   parameter int ANGLE_FRAC_BITS = 7,
   parameter int CORDIC_STEPS    = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [31:0]                    req_tdata,  // sample_x, sample_y
   input  logic                           req_tuser,  // restart_filter
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [95:0]                    rsp_tdata,  // cal_x, cal_y, raw heading, filtered heading
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [cmpk_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]                    csr_data
);

   cmpk_pkg::cfg_type cfg;
   cmpk_pkg::cmd_type cmd;
   cmpk_pkg::sts_type sts;

   cmpk_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg_o     (cfg)
   );

   cmpk_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts_i      (sts),
      .cmd_o      (cmd)
   );

   cmpk_dp #(
      .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS),
      .CORDIC_STEPS    (CORDIC_STEPS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cfg_i      (cfg),
      .cmd_i      (cmd),
      .sts_o      (sts),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

[hdl/cmpk_csr.sv]
// Configuration register file of the compass filter.
`timescale 1ns / 1ps
module cmpk_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [cmpk_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]                    csr_data,
   output cmpk_pkg::cfg_type              cfg_o
);

   cmpk_pkg::cfg_type cfg_ff, cfg_in;

   assign csr_ready = 1'b1;
   assign cfg_o     = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            cmpk_pkg::REG_OFFSET_X:       cfg_in.offset_x       = csr_data[16:0];
            cmpk_pkg::REG_OFFSET_Y:       cfg_in.offset_y       = csr_data[16:0];
            cmpk_pkg::REG_SCALE_X:        cfg_in.scale_x        = csr_data[23:0];
            cmpk_pkg::REG_SCALE_Y:        cfg_in.scale_y        = csr_data[23:0];
            cmpk_pkg::REG_PROCESS_NOISE:  cfg_in.process_noise  = csr_data;
            cmpk_pkg::REG_NOISE_STILL:    cfg_in.noise_still    = csr_data;
            cmpk_pkg::REG_NOISE_TURN:     cfg_in.noise_turn     = csr_data;
            cmpk_pkg::REG_TURN_THRESHOLD: cfg_in.turn_threshold = csr_data[14:0];
            default:                      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.offset_x       <= '0;
         cfg_ff.offset_y       <= '0;
         cfg_ff.scale_x        <= cmpk_pkg::SCALE_RESET;
         cfg_ff.scale_y        <= cmpk_pkg::SCALE_RESET;
         cfg_ff.process_noise  <= cmpk_pkg::PROCESS_NOISE_RESET;
         cfg_ff.noise_still    <= cmpk_pkg::NOISE_STILL_RESET;
         cfg_ff.noise_turn     <= cmpk_pkg::NOISE_TURN_RESET;
         cfg_ff.turn_threshold <= cmpk_pkg::THRESHOLD_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

[hdl/cmpk_ctrl.sv]
// Sequencing state machine of the compass filter.
`timescale 1ns / 1ps
module cmpk_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  cmpk_pkg::sts_type sts_i,
   output cmpk_pkg::cmd_type cmd_o
);

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_CAL   = 4'd1;
   localparam logic [3:0] S_RND   = 4'd2;
   localparam logic [3:0] S_CINIT = 4'd3;
   localparam logic [3:0] S_CSTEP = 4'd4;
   localparam logic [3:0] S_CONV  = 4'd5;
   localparam logic [3:0] S_HEAD  = 4'd6;
   localparam logic [3:0] S_KAL   = 4'd7;
   localparam logic [3:0] S_SEL   = 4'd8;
   localparam logic [3:0] S_DSTEP = 4'd9;
   localparam logic [3:0] S_MUL   = 4'd10;
   localparam logic [3:0] S_FIN   = 4'd11;
   localparam logic [3:0] S_DONE  = 4'd12;

   logic [3:0] state_ff, state_in;

   always_comb begin
      state_in   = state_ff;
      cmd_o      = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd_o.load = 1'b1;
               state_in   = S_CAL;
            end
         end
         S_CAL: begin
            cmd_o.cal = 1'b1;
            state_in  = S_RND;
         end
         S_RND: begin
            cmd_o.rnd = 1'b1;
            state_in  = S_CINIT;
         end
         S_CINIT: begin
            cmd_o.cinit = 1'b1;
            state_in    = S_CSTEP;
         end
         S_CSTEP: begin
            cmd_o.cstep = 1'b1;
            if (sts_i.cordic_last) state_in = S_CONV;
         end
         S_CONV: begin
            cmd_o.conv = 1'b1;
            state_in   = S_HEAD;
         end
         S_HEAD: begin
            cmd_o.head = 1'b1;
            state_in   = S_KAL;
         end
         S_KAL: begin
            cmd_o.kal = 1'b1;
            state_in  = sts_i.init ? S_DONE : S_SEL;
         end
         S_SEL: begin
            cmd_o.sel = 1'b1;
            state_in  = S_DSTEP;
         end
         S_DSTEP: begin
            cmd_o.dstep = 1'b1;
            if (sts_i.div_last) state_in = S_MUL;
         end
         S_MUL: begin
            cmd_o.mul = 1'b1;
            state_in  = S_FIN;
         end
         S_FIN: begin
            cmd_o.fin = 1'b1;
            state_in  = S_DONE;
         end
         S_DONE: begin
            if (sts_i.out_free) begin
               cmd_o.out = 1'b1;
               state_in  = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[hdl/cmpk_dp.sv]
// Datapath of the compass filter: calibration, CORDIC heading, serial divider and filter state.
`timescale 1ns / 1ps
module cmpk_dp #(
   parameter int ANGLE_FRAC_BITS = 7,
   parameter int CORDIC_STEPS    = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  cmpk_pkg::cfg_type cfg_i,
   input  cmpk_pkg::cmd_type cmd_i,
   output cmpk_pkg::sts_type sts_o,
   input  logic [31:0]       req_tdata,
   input  logic              req_tuser,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [95:0]       rsp_tdata
);

   localparam int FULL = 360 << ANGLE_FRAC_BITS;
   localparam int HALF = 180 << ANGLE_FRAC_BITS;
   localparam int AW   = $clog2(FULL);
   localparam int EW   = AW + 2;
   localparam int CW   = $clog2(CORDIC_STEPS);
   localparam int HW   = 32 + AW;

   function automatic logic signed [31:0] sat32(input logic signed [43:0] v);
      logic signed [31:0] r;
      if (v > 44'sd2147483647) r = 32'sh7FFFFFFF;
      else if (v < -44'sd2147483648) r = 32'sh80000000;
      else r = v[31:0];
      return r;
   endfunction

   logic signed [15:0]    sx_ff, sx_in, sy_ff, sy_in;
   logic                  restart_ff, restart_in;
   logic signed [43:0]    prodx_ff, prodx_in, prody_ff, prody_in;
   logic signed [31:0]    calx_ff, calx_in, caly_ff, caly_in;
   logic signed [35:0]    cx_ff, cx_in, cy_ff, cy_in;
   logic [31:0]           ang_ff, ang_in;
   logic                  zero_ff, zero_in;
   logic [CW-1:0]         it_ff, it_in;
   logic [HW-1:0]         hprod_ff, hprod_in;
   logic [AW-1:0]         meas_ff, meas_in;
   logic [31:0]           p_ff, p_in;
   logic signed [EW-1:0]  err_ff, err_in;
   logic [32:0]           den_ff, den_in;
   logic [16:0]           num_ff, num_in;
   logic [32:0]           rem_ff, rem_in;
   logic [16:0]           q_ff, q_in;
   logic [4:0]            dcnt_ff, dcnt_in;
   logic                  dz_ff, dz_in;
   logic signed [EW+17:0] aprod_ff, aprod_in;
   logic [48:0]           pprod_ff, pprod_in;
   logic [AW-1:0]         angle_ff, angle_in;
   logic [31:0]           var_ff, var_in;
   logic                  started_ff, started_in;
   logic                  rvalid_ff, rvalid_in;
   logic [95:0]           rdata_ff, rdata_in;

   logic signed [18:0]    dx, dy;
   logic signed [35:0]    xs, ys;
   logic [HW:0]           hsum;
   logic [AW:0]           hcand;
   logic [32:0]           psum;
   logic signed [EW-1:0]  e, mag;
   logic [31:0]           rsel;
   logic [32:0]           den;
   logic [48:0]           num;
   logic [33:0]           trial;
   logic                  ge;
   logic [16:0]           k;
   logic signed [EW+18:0] asum;
   logic signed [EW+18:0] delta;
   logic signed [EW-1:0]  nang;
   logic [49:0]           vsum;
   logic                  init_w;

   assign init_w           = !started_ff || restart_ff;
   assign sts_o.init       = init_w;
   assign sts_o.cordic_last = it_ff == CW'(CORDIC_STEPS - 1);
   assign sts_o.div_last   = dcnt_ff == 5'd16;
   assign sts_o.out_free   = !rvalid_ff || rsp_tready;
   assign rsp_tvalid       = rvalid_ff;
   assign rsp_tdata        = rdata_ff;

   always_comb begin
      sx_in = sx_ff;  sy_in = sy_ff;  restart_in = restart_ff;
      prodx_in = prodx_ff;  prody_in = prody_ff;
      calx_in = calx_ff;  caly_in = caly_ff;
      cx_in = cx_ff;  cy_in = cy_ff;  ang_in = ang_ff;  zero_in = zero_ff;  it_in = it_ff;
      hprod_in = hprod_ff;  meas_in = meas_ff;
      p_in = p_ff;  err_in = err_ff;
      den_in = den_ff;  num_in = num_ff;  rem_in = rem_ff;  q_in = q_ff;
      dcnt_in = dcnt_ff;  dz_in = dz_ff;
      aprod_in = aprod_ff;  pprod_in = pprod_ff;
      angle_in = angle_ff;  var_in = var_ff;  started_in = started_ff;
      rvalid_in = rvalid_ff;  rdata_in = rdata_ff;

      dx    = (19'(sx_ff) <<< 1) - 19'(cfg_i.offset_x);
      dy    = (19'(sy_ff) <<< 1) - 19'(cfg_i.offset_y);
      xs    = cx_ff >>> it_ff;
      ys    = cy_ff >>> it_ff;
      hsum  = {1'b0, hprod_ff} + (HW+1)'(33'h080000000);
      hcand = hsum[HW:32];
      psum  = {1'b0, var_ff} + {1'b0, cfg_i.process_noise};
      e     = $signed({2'b00, meas_ff}) - $signed({2'b00, angle_ff});
      mag   = err_ff[EW-1] ? -err_ff : err_ff;
      rsel  = (32'(mag) < 32'(cfg_i.turn_threshold)) ? cfg_i.noise_still : cfg_i.noise_turn;
      den   = {1'b0, p_ff} + {1'b0, rsel};
      num   = {1'b0, p_ff, 16'h0000} + 49'(den[32:1]);
      trial = {rem_ff, num_ff[16]};
      ge    = trial >= {1'b0, den_ff};
      k     = dz_ff ? 17'd0 : q_ff;
      asum  = (EW+19)'(aprod_ff) + (EW+19)'(32768);
      delta = asum >>> 16;
      nang  = $signed({2'b00, angle_ff}) + delta[EW-1:0];
      vsum  = {1'b0, pprod_ff} + 50'd32768;

      if (cmd_i.load) begin
         sx_in      = req_tdata[15:0];
         sy_in      = req_tdata[31:16];
         restart_in = req_tuser;
      end
      if (cmd_i.cal) begin
         prodx_in = dx * $signed({1'b0, cfg_i.scale_x});
         prody_in = dy * $signed({1'b0, cfg_i.scale_y});
      end
      if (cmd_i.rnd) begin
         calx_in = sat32((prodx_ff + 44'sd256) >>> 9);
         caly_in = sat32((prody_ff + 44'sd256) >>> 9);
      end
      if (cmd_i.cinit) begin
         zero_in = (calx_ff == 32'sd0) && (caly_ff == 32'sd0);
         it_in   = '0;
         if (calx_ff < 32'sd0) begin
            cx_in  = -36'(calx_ff);
            cy_in  = -36'(caly_ff);
            ang_in = 32'h80000000;
         end else begin
            cx_in  = 36'(calx_ff);
            cy_in  = 36'(caly_ff);
            ang_in = 32'h00000000;
         end
      end
      if (cmd_i.cstep) begin
         it_in = it_ff + CW'(1);
         if (cy_ff > 36'sd0) begin
            cx_in  = cx_ff + ys;
            cy_in  = cy_ff - xs;
            ang_in = ang_ff + cmpk_pkg::atan_entry(cmpk_pkg::TAB_IW'(it_ff));
         end else begin
            cx_in  = cx_ff - ys;
            cy_in  = cy_ff + xs;
            ang_in = ang_ff - cmpk_pkg::atan_entry(cmpk_pkg::TAB_IW'(it_ff));
         end
      end
      if (cmd_i.conv) begin
         hprod_in = HW'(ang_ff) * HW'(FULL);
      end
      if (cmd_i.head) begin
         if (zero_ff || hcand >= (AW+1)'(FULL)) meas_in = '0;
         else meas_in = hcand[AW-1:0];
      end
      if (cmd_i.kal) begin
         if (init_w) begin
            angle_in   = meas_ff;
            var_in     = cmpk_pkg::VARIANCE_ONE;
            started_in = 1'b1;
         end else begin
            p_in = psum[32] ? 32'hFFFFFFFF : psum[31:0];
            if (e > EW'(HALF)) err_in = e - EW'(FULL);
            else if (e < -EW'(HALF)) err_in = e + EW'(FULL);
            else err_in = e;
         end
      end
      if (cmd_i.sel) begin
         den_in  = den;
         num_in  = num[16:0];
         rem_in  = {1'b0, num[48:17]};
         q_in    = '0;
         dcnt_in = '0;
         dz_in   = den == 33'd0;
      end
      if (cmd_i.dstep) begin
         rem_in  = ge ? 33'(trial - {1'b0, den_ff}) : trial[32:0];
         num_in  = {num_ff[15:0], 1'b0};
         q_in    = {q_ff[15:0], ge};
         dcnt_in = dcnt_ff + 5'd1;
      end
      if (cmd_i.mul) begin
         aprod_in = $signed({1'b0, k}) * err_ff;
         pprod_in = 49'(17'd65536 - k) * 49'(p_ff);
      end
      if (cmd_i.fin) begin
         if (nang >= EW'(FULL)) angle_in = AW'(nang - EW'(FULL));
         else if (nang < 0) angle_in = AW'(nang + EW'(FULL));
         else angle_in = AW'(nang);
         var_in = vsum[47:16];
      end
      if (rvalid_ff && rsp_tready) rvalid_in = 1'b0;
      if (cmd_i.out) begin
         rvalid_in = 1'b1;
         rdata_in  = {16'(angle_ff), 16'(meas_ff), caly_ff, calx_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         angle_ff   <= '0;
         var_ff     <= cmpk_pkg::VARIANCE_ONE;
         started_ff <= 1'b0;
         rvalid_ff  <= 1'b0;
         it_ff      <= '0;
         dcnt_ff    <= '0;
      end else begin
         angle_ff   <= angle_in;
         var_ff     <= var_in;
         started_ff <= started_in;
         rvalid_ff  <= rvalid_in;
         it_ff      <= it_in;
         dcnt_ff    <= dcnt_in;
      end
   end

   always_ff @(posedge clock) begin
      sx_ff <= sx_in;  sy_ff <= sy_in;  restart_ff <= restart_in;
      prodx_ff <= prodx_in;  prody_ff <= prody_in;
      calx_ff <= calx_in;  caly_ff <= caly_in;
      cx_ff <= cx_in;  cy_ff <= cy_in;  ang_ff <= ang_in;  zero_ff <= zero_in;
      hprod_ff <= hprod_in;  meas_ff <= meas_in;
      p_ff <= p_in;  err_ff <= err_in;
      den_ff <= den_in;  num_ff <= num_in;  rem_ff <= rem_in;  q_ff <= q_in;  dz_ff <= dz_in;
      aprod_ff <= aprod_in;  pprod_ff <= pprod_in;
      rdata_ff <= rdata_in;
   end

   a_angle_range: assert property (@(posedge clock) disable iff (reset)
      angle_ff < AW'(FULL))
      else $error("Filtered angle left the range of one turn.");

   a_meas_range: assert property (@(posedge clock) disable iff (reset)
      cmd_i.head |=> meas_ff < AW'(FULL))
      else $error("Raw heading left the range of one turn.");

   a_var_hold: assert property (@(posedge clock) disable iff (reset)
      (!cmd_i.fin && !cmd_i.kal) |=> $stable(var_ff))
      else $error("Variance changed outside an update.");

   a_gain_range: assert property (@(posedge clock) disable iff (reset)
      (cmd_i.mul && !dz_ff) |-> q_ff <= 17'd65536)
      else $error("Kalman gain exceeds one.");

endmodule
